/* rtl/tgsq_pkg.sv */
// Shared types and constants for the touch gesture sample queue.
package tgsq_pkg;

  localparam int QUEUE_DEPTH    = 16;
  localparam int PAYLOAD_BITS   = 32;
  localparam int PAYLOAD_PORT   = 32;
  localparam int DISC_BITS      = 5;
  localparam int POS_BITS       = 8;
  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_DISCARD = 2'd2,
    FUNC_RETAIN  = 2'd3
  } func_t;

  localparam logic [1:0] KIND_PRESS   = 2'd0;
  localparam logic [1:0] KIND_MOVE    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;
  localparam logic [1:0] KIND_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_SHIFT  = 3'd1,
    CELL_ROT    = 3'd2,
    CELL_APPEND = 3'd3,
    CELL_SETPAY = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [POS_BITS-1:0] pos;
  } cell_cmd_t;

  typedef struct packed {
    logic [DISC_BITS-1:0]    disc;
    logic                    has_more;
    logic [PAYLOAD_PORT-1:0] payload;
    logic [1:0]              kind;
    logic                    ok;
  } res_t;

endpackage

/* rtl/tgsq_cell.sv */
// One queue cell: holds one sample and takes its neighbor's sample, the head sample or a written sample on command.
module tgsq_cell #(
  parameter int CELL_IDX     = 0,
  parameter int PAYLOAD_BITS = tgsq_pkg::PAYLOAD_BITS
) (
  input  logic                      clk,
  input  tgsq_pkg::cell_cmd_t       cmd,
  input  logic [1:0]                next_kind,
  input  logic [PAYLOAD_BITS-1:0]   next_pay,
  input  logic [1:0]                head_kind,
  input  logic [PAYLOAD_BITS-1:0]   head_pay,
  input  logic [1:0]                wr_kind,
  input  logic [PAYLOAD_BITS-1:0]   wr_pay,
  output logic [1:0]                kind,
  output logic [PAYLOAD_BITS-1:0]   pay
);

  localparam logic [tgsq_pkg::POS_BITS-1:0] MY_POS = tgsq_pkg::POS_BITS'(CELL_IDX);

  logic [1:0]              kind_r, kind_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;

  always_comb begin
    kind_nxt = kind_r;
    pay_nxt  = pay_r;
    case (cmd.op)
      tgsq_pkg::CELL_SHIFT: begin
        // close up from pos: every cell at or above pos takes its upper neighbor
        if (MY_POS >= cmd.pos) begin
          kind_nxt = next_kind;
          pay_nxt  = next_pay;
        end
      end
      tgsq_pkg::CELL_ROT: begin
        // pos marks the last occupied cell, which takes the head
        if (MY_POS < cmd.pos) begin
          kind_nxt = next_kind;
          pay_nxt  = next_pay;
        end else if (MY_POS == cmd.pos) begin
          kind_nxt = head_kind;
          pay_nxt  = head_pay;
        end
      end
      tgsq_pkg::CELL_APPEND: begin
        if (MY_POS == cmd.pos) begin
          kind_nxt = wr_kind;
          pay_nxt  = wr_pay;
        end
      end
      tgsq_pkg::CELL_SETPAY: begin
        if (MY_POS == cmd.pos) begin
          pay_nxt = wr_pay;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    pay_r  <= pay_nxt;
  end

  assign kind = kind_r;
  assign pay  = pay_r;

endmodule

/* rtl/tgsq_seq.sv */
// Sequencer: decodes each operation, scans the cell row and drives the cells.
module tgsq_seq #(
  parameter int QUEUE_DEPTH  = tgsq_pkg::QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tgsq_pkg::PAYLOAD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [1:0]                        in_func,
  input  logic [1:0]                        in_kind,
  input  logic [tgsq_pkg::PAYLOAD_PORT-1:0] in_pay,
  input  logic [1:0]                        head_kind,
  input  logic [PAYLOAD_BITS-1:0]           head_pay,
  output tgsq_pkg::cell_cmd_t               cmd,
  output logic [1:0]                        wr_kind,
  output logic [PAYLOAD_BITS-1:0]           wr_pay,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output tgsq_pkg::res_t                    out_res
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PB    = tgsq_pkg::POS_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_DROP,
    ST_APPEND,
    ST_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [1:0]              tail_kind_r, tail_kind_nxt;
  tgsq_pkg::func_t         func_r, func_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [IDX_W-1:0]        scan_k_r, scan_k_nxt;
  logic [IDX_W-1:0]        first_rel_r, first_rel_nxt;
  logic                    first_rel_vld_r, first_rel_vld_nxt;
  logic [IDX_W-1:0]        last_rel_r, last_rel_nxt;
  logic                    last_rel_vld_r, last_rel_vld_nxt;
  logic [IDX_W-1:0]        first_mov_r, first_mov_nxt;
  logic                    first_mov_vld_r, first_mov_vld_nxt;
  logic [CNT_W-1:0]        drop_left_r, drop_left_nxt;
  tgsq_pkg::res_t          res_r, res_nxt;
  tgsq_pkg::res_t          out_res_r, out_res_nxt;
  logic                    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    tail_kind_nxt     = tail_kind_r;
    func_nxt          = func_r;
    kind_nxt          = kind_r;
    pay_nxt           = pay_r;
    scan_k_nxt        = scan_k_r;
    first_rel_nxt     = first_rel_r;
    first_rel_vld_nxt = first_rel_vld_r;
    last_rel_nxt      = last_rel_r;
    last_rel_vld_nxt  = last_rel_vld_r;
    first_mov_nxt     = first_mov_r;
    first_mov_vld_nxt = first_mov_vld_r;
    drop_left_nxt     = drop_left_r;
    res_nxt           = res_r;
    out_res_nxt       = out_res_r;
    out_valid_nxt     = out_valid_r && !out_tready;
    cmd.op            = tgsq_pkg::CELL_HOLD;
    cmd.pos           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt  = tgsq_pkg::func_t'(in_func);
          kind_nxt  = in_kind;
          pay_nxt   = PAYLOAD_BITS'(in_pay);
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_nxt           = '0;
        scan_k_nxt        = '0;
        first_rel_vld_nxt = 1'b0;
        last_rel_vld_nxt  = 1'b0;
        first_mov_vld_nxt = 1'b0;
        state_nxt         = ST_DONE;
        unique case (func_r)
          tgsq_pkg::FUNC_PUSH: begin
            if (kind_r == tgsq_pkg::KIND_UNUSED) begin
              state_nxt = ST_DONE;
            end else if (kind_r == tgsq_pkg::KIND_MOVE && cnt_r != '0 &&
                         tail_kind_r == tgsq_pkg::KIND_MOVE) begin
              // coalesce onto the trailing move
              cmd.op     = tgsq_pkg::CELL_SETPAY;
              cmd.pos    = PB'(cnt_r - CNT_W'(1));
              res_nxt.ok = 1'b1;
            end else if (cnt_r != CNT_W'(QUEUE_DEPTH)) begin
              state_nxt = ST_APPEND;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          tgsq_pkg::FUNC_POP: begin
            if (cnt_r != '0) begin
              cmd.op           = tgsq_pkg::CELL_SHIFT;
              cmd.pos          = '0;
              cnt_nxt          = cnt_r - CNT_W'(1);
              res_nxt.ok       = 1'b1;
              res_nxt.kind     = head_kind;
              res_nxt.payload  = tgsq_pkg::PAYLOAD_PORT'(head_pay);
              res_nxt.has_more = (cnt_r != CNT_W'(1));
            end
          end
          default: begin
            if (cnt_r != '0) begin
              state_nxt = ST_SCAN;
            end
          end
        endcase
      end

      ST_SCAN: begin
        // rotate the occupied cells once around, watching the head
        cmd.op  = tgsq_pkg::CELL_ROT;
        cmd.pos = PB'(cnt_r - CNT_W'(1));
        if (head_kind == tgsq_pkg::KIND_RELEASE) begin
          if (!first_rel_vld_r) begin
            first_rel_nxt     = scan_k_r;
            first_rel_vld_nxt = 1'b1;
          end
          last_rel_nxt     = scan_k_r;
          last_rel_vld_nxt = 1'b1;
        end
        if (head_kind == tgsq_pkg::KIND_MOVE && !first_mov_vld_r) begin
          first_mov_nxt     = scan_k_r;
          first_mov_vld_nxt = 1'b1;
        end
        if (CNT_W'(scan_k_r) + CNT_W'(1) == cnt_r) begin
          state_nxt = ST_DECIDE;
        end else begin
          scan_k_nxt = scan_k_r + IDX_W'(1);
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_DONE;
        unique case (func_r)
          tgsq_pkg::FUNC_PUSH: begin
            if (first_rel_vld_r) begin
              drop_left_nxt = CNT_W'(first_rel_r) + CNT_W'(1);
              state_nxt     = ST_DROP;
            end else if (first_mov_vld_r) begin
              cmd.op    = tgsq_pkg::CELL_SHIFT;
              cmd.pos   = PB'(first_mov_r);
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = ST_APPEND;
            end
          end
          tgsq_pkg::FUNC_DISCARD: begin
            if (last_rel_vld_r) begin
              drop_left_nxt = CNT_W'(last_rel_r) + CNT_W'(1);
              res_nxt.disc  = tgsq_pkg::DISC_BITS'(CNT_W'(last_rel_r) + CNT_W'(1));
              res_nxt.ok    = 1'b1;
              state_nxt     = ST_DROP;
            end
          end
          tgsq_pkg::FUNC_RETAIN: begin
            if (first_rel_vld_r) begin
              res_nxt.ok = 1'b1;
              if (first_rel_r == '0) begin
                cnt_nxt       = CNT_W'(1);
                tail_kind_nxt = tgsq_pkg::KIND_RELEASE;
              end else begin
                drop_left_nxt = CNT_W'(first_rel_r);
                state_nxt     = ST_DROP;
              end
            end
          end
          default: ;
        endcase
      end

      ST_DROP: begin
        cmd.op        = tgsq_pkg::CELL_SHIFT;
        cmd.pos       = '0;
        cnt_nxt       = cnt_r - CNT_W'(1);
        drop_left_nxt = drop_left_r - CNT_W'(1);
        if (drop_left_r == CNT_W'(1)) begin
          state_nxt = ST_DONE;
          if (func_r == tgsq_pkg::FUNC_PUSH) begin
            state_nxt = ST_APPEND;
          end else if (func_r == tgsq_pkg::FUNC_RETAIN) begin
            cnt_nxt       = CNT_W'(1);
            tail_kind_nxt = tgsq_pkg::KIND_RELEASE;
          end
        end
      end

      ST_APPEND: begin
        cmd.op        = tgsq_pkg::CELL_APPEND;
        cmd.pos       = PB'(cnt_r);
        cnt_nxt       = cnt_r + CNT_W'(1);
        tail_kind_nxt = kind_r;
        res_nxt.ok    = 1'b1;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tail_kind_r <= tgsq_pkg::KIND_PRESS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tail_kind_r <= tail_kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r          <= func_nxt;
    kind_r          <= kind_nxt;
    pay_r           <= pay_nxt;
    scan_k_r        <= scan_k_nxt;
    first_rel_r     <= first_rel_nxt;
    first_rel_vld_r <= first_rel_vld_nxt;
    last_rel_r      <= last_rel_nxt;
    last_rel_vld_r  <= last_rel_vld_nxt;
    first_mov_r     <= first_mov_nxt;
    first_mov_vld_r <= first_mov_vld_nxt;
    drop_left_r     <= drop_left_nxt;
    res_r           <= res_nxt;
    out_res_r       <= out_res_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign wr_kind    = kind_r;
  assign wr_pay     = pay_r;
  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule

/* rtl/touch_gesture_sample_queue_unit.sv */
// Top level of the touch gesture sample queue: cell row plus sequencer.
// Path from the accept to out_tvalid: pop, coalesce, an unused kind and an empty queue go
// through dispatch and done; a push into a non-full queue adds an append step; a scan op rotates
// through every stored entry, decides, drops entries one by one and appends when a full-queue push lands.
// Throughput: one word in flight; in_tready rises together with out_tvalid, so the next is accepted after it.
// Reset: synchronous active-low rst_n empties the queue; cell contents are not cleared.
module touch_gesture_sample_queue_unit #(
  parameter int QUEUE_DEPTH  = tgsq_pkg::QUEUE_DEPTH,
  parameter int PAYLOAD_BITS = tgsq_pkg::PAYLOAD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, from bit 0: func[1:0], sample_kind[3:2], sample_payload[35:4], zero pad
  input  logic [tgsq_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata, from bit 0: ok[0], out_kind[2:1], out_payload[34:3], has_more[35],
  // discarded_count[40:36], zero pad
  output logic [tgsq_pkg::OUT_TDATA_BITS-1:0] out_tdata
);

  tgsq_pkg::cell_cmd_t     cmd;
  tgsq_pkg::res_t          res;
  logic [1:0]              wr_kind;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  // Cell outputs, one per position; cell 0 is always the head of the queue
  logic [1:0]              cell_kind [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay  [QUEUE_DEPTH];

  tgsq_seq #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tdata[1:0]),
    .in_kind    (in_tdata[3:2]),
    .in_pay     (in_tdata[35:4]),
    .head_kind  (cell_kind[0]),
    .head_pay   (cell_pay[0]),
    .cmd        (cmd),
    .wr_kind    (wr_kind),
    .wr_pay     (wr_pay),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Each cell hands its sample down to its lower neighbor; the top cell
  // sees itself, and the head sample is broadcast for rotation.
  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    logic [1:0]              nk;
    logic [PAYLOAD_BITS-1:0] np;

    if (gi == QUEUE_DEPTH - 1) begin : g_top
      assign nk = cell_kind[gi];
      assign np = cell_pay[gi];
    end else begin : g_mid
      assign nk = cell_kind[gi+1];
      assign np = cell_pay[gi+1];
    end

    tgsq_cell #(
      .CELL_IDX     (gi),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .next_kind (nk),
      .next_pay  (np),
      .head_kind (cell_kind[0]),
      .head_pay  (cell_pay[0]),
      .wr_kind   (wr_kind),
      .wr_pay    (wr_pay),
      .kind      (cell_kind[gi]),
      .pay       (cell_pay[gi])
    );
  end

  // Pack the result word, first field in the low bits
  assign out_tdata = {7'd0, res.disc, res.has_more, res.payload, res.kind, res.ok};

endmodule

/* rtl/tgsq_checker.sv */
// Port-level checker for the touch gesture sample queue, bound to the top level.
module tgsq_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [tgsq_pkg::OUT_TDATA_BITS-1:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // one word in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // a refused operation carries nothing but zeros
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[40:1] == 40'd0)
    else $error("refused operation returned data");

  // a discard count never comes with popped data
  a_disc_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[40:36] != 5'd0 |-> out_tdata[35:1] == 35'd0)
    else $error("discard count mixed with pop data");

  // drop any pending result on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind touch_gesture_sample_queue_unit tgsq_checker u_tgsq_checker (.*);
